### src/ipos_pkg.sv
// Package for the IPv4 option security strip block.
// Holds the parser state and result types, register indexes and reset codes.
// No dependencies.
package ipos_pkg;

    localparam int CNT_W = 6;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_SECURITY   = 2'd0,
        CFG_EXTENDED   = 2'd1,
        CFG_COMMERCIAL = 2'd2
    } t_cfg_index;

    localparam logic [7:0] RST_CODE_SECURITY   = 8'd130;
    localparam logic [7:0] RST_CODE_EXTENDED   = 8'd133;
    localparam logic [7:0] RST_CODE_COMMERCIAL = 8'd134;

    localparam logic [7:0] OPT_END = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_MIN_LEN = 8'd2;
    localparam logic [7:0] BODY_CAP = 8'd63;

    typedef struct packed {
        t_phase     phase;
        t_count     bytes_left;
        logic       dropping;
        t_count     kept_total;
        t_count     bytes_seen;
        logic       error_seen;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:      PH_TYPE,
        bytes_left: '0,
        dropping:   1'b0,
        kept_total: '0,
        bytes_seen: '0,
        error_seen: 1'b0
    };

    typedef struct packed {
        logic       has_result;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_last;
        t_count     kept_count;
        logic       malformed;
    } t_result;

endpackage

### src/ipos_parse.sv
// Option area parser: next state and result for one option byte.
// Purely combinational; uses ipos_pkg types and constants.
module ipos_parse #(
    parameter int MAX_OPT_BYTES = 40
) (
    input  ipos_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [7:0]             i_code_security,
    input  logic [7:0]             i_code_extended,
    input  logic [7:0]             i_code_commercial,
    output ipos_pkg::t_parse_state o_next,
    output ipos_pkg::t_result      o_result
);

    localparam ipos_pkg::t_count MaxBytes = ipos_pkg::CNT_W'(MAX_OPT_BYTES);

    ipos_pkg::t_parse_state w_work;
    logic                   w_keep;
    logic [7:0]             w_body;

    assign w_body = i_byte - ipos_pkg::OPT_MIN_LEN;

    // next state
    always_comb begin
        w_work = i_state;
        w_keep = 1'b0;
        if (i_state.bytes_seen >= MaxBytes) begin
            w_work.error_seen = 1'b1;
        end else begin
            w_work.bytes_seen = i_state.bytes_seen + 1'b1;
            case (i_state.phase)
                ipos_pkg::PH_TYPE: begin
                    if (i_byte == ipos_pkg::OPT_END) begin
                        w_work.phase = ipos_pkg::PH_STOP;
                    end else if (i_byte != ipos_pkg::OPT_NOP) begin
                        w_work.dropping = (i_byte == i_code_security) ||
                                          (i_byte == i_code_extended) ||
                                          (i_byte == i_code_commercial);
                        w_keep = !w_work.dropping;
                        w_work.phase = ipos_pkg::PH_LEN;
                    end
                end
                ipos_pkg::PH_LEN: begin
                    if (i_byte < ipos_pkg::OPT_MIN_LEN) begin
                        w_work.error_seen = 1'b1;
                        w_work.phase = ipos_pkg::PH_STOP;
                    end else begin
                        w_keep = !i_state.dropping;
                        if (i_byte == ipos_pkg::OPT_MIN_LEN) begin
                            w_work.phase = ipos_pkg::PH_TYPE;
                        end else begin
                            w_work.bytes_left = (w_body > ipos_pkg::BODY_CAP) ?
                                ipos_pkg::CNT_W'(ipos_pkg::BODY_CAP) :
                                w_body[ipos_pkg::CNT_W-1:0];
                            w_work.phase = ipos_pkg::PH_BODY;
                        end
                    end
                end
                ipos_pkg::PH_BODY: begin
                    w_keep = !i_state.dropping;
                    if (i_state.bytes_left > 1) begin
                        w_work.bytes_left = i_state.bytes_left - 1'b1;
                    end else begin
                        w_work.bytes_left = '0;
                        w_work.phase = ipos_pkg::PH_TYPE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_keep) begin
            w_work.kept_total = i_state.kept_total + 1'b1;
        end
        if (i_last && (w_work.phase == ipos_pkg::PH_LEN ||
                       w_work.phase == ipos_pkg::PH_BODY)) begin
            w_work.error_seen = 1'b1;
        end
        // clear per-area state after the final byte
        o_next = i_last ? ipos_pkg::PARSE_RESET : w_work;
    end

    // result
    always_comb begin
        o_result.has_result = w_keep || i_last;
        o_result.out_byte   = w_keep ? i_byte : 8'd0;
        o_result.byte_valid = w_keep;
        o_result.is_last    = i_last;
        o_result.kept_count = w_work.kept_total;
        o_result.malformed  = w_work.error_seen;
    end

endmodule

### src/ip_option_security_strip_top.sv
// Top level of the IPv4 option security strip block.
// Input register, parser (ipos_parse), result register; uses ipos_pkg.
//
// Usage:
//   The option area of one IPv4 header enters one byte per item on the
//   input channel (i_in_valid / o_in_ready), with i_end_of_area high on the
//   last byte. Kept option bytes leave on the result channel
//   (o_out_valid / i_out_ready). A byte that is dropped (no-operation,
//   security option, bytes after end of list) makes no item unless it is
//   the last byte of the area; the last byte always makes one item that
//   carries is_last, the final kept_count and the malformed flag.
//   Drop codes are written on the config channel (i_cfg_valid, index,
//   data); o_cfg_ready is always high. Write them only while idle.
// Pipeline and throughput:
//   An accepted byte sits in the input register until the result register
//   is free or being drained; then its result enters the result register.
//   One byte per cycle is sustained while the receiver does not stall: the
//   parser state update is a single short step per byte.
// Reset and stalls:
//   Reset clears the parser state and both stage valids and loads the
//   default drop codes 130, 133 and 134. When the receiver stalls, the
//   result register holds and the input register still takes one more
//   byte; after that o_in_ready drops until the result is taken.
module ip_option_security_strip_top #(
    parameter int MAX_OPT_BYTES = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_opt_byte,
    input  logic       i_end_of_area,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_is_last,
    output logic [5:0] o_kept_count,
    output logic       o_malformed,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // drop code registers
    logic [7:0] r_code_security;
    logic [7:0] r_code_extended;
    logic [7:0] r_code_commercial;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state and result register
    ipos_pkg::t_parse_state r_state;
    ipos_pkg::t_parse_state n_state;
    ipos_pkg::t_result      w_result;
    ipos_pkg::t_result      r_out;
    logic                   r_out_valid;

    logic w_adv;

    // advance the held byte when the result register is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_security   <= ipos_pkg::RST_CODE_SECURITY;
            r_code_extended   <= ipos_pkg::RST_CODE_EXTENDED;
            r_code_commercial <= ipos_pkg::RST_CODE_COMMERCIAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ipos_pkg::CFG_SECURITY:   r_code_security   <= i_cfg_data;
                ipos_pkg::CFG_EXTENDED:   r_code_extended   <= i_cfg_data;
                ipos_pkg::CFG_COMMERCIAL: r_code_commercial <= i_cfg_data;
                default: begin
                    // unused index: ignore the write
                end
            endcase
        end
    end

    // input register: take a new byte whenever the stage is empty or moving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_opt_byte;
            r_in_last <= i_end_of_area;
        end
    end

    ipos_parse #(
        .MAX_OPT_BYTES (MAX_OPT_BYTES)
    ) u_parse (
        .i_state           (r_state),
        .i_byte            (r_in_byte),
        .i_last            (r_in_last),
        .i_code_security   (r_code_security),
        .i_code_extended   (r_code_extended),
        .i_code_commercial (r_code_commercial),
        .o_next            (n_state),
        .o_result          (w_result)
    );

    // parser state advances once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipos_pkg::PARSE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register: load on advance, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_result.has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_valid = r_out.byte_valid;
    assign o_is_last    = r_out.is_last;
    assign o_kept_count = r_out.kept_count;
    assign o_malformed  = r_out.malformed;

`ifndef NO_ASSERTIONS
    // kept count is bounded by the area limit
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kept_count <= 6'(MAX_OPT_BYTES)))
        else $error("kept_count exceeds area limit");

    // an item without a kept byte exists only for the final byte, and carries zero
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_is_last && o_out_byte == 8'd0))
        else $error("result without kept byte is not the final one");

    // per-area state is cleared after the final byte is processed
    a_area_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=>
            (r_state.kept_total == '0 && r_state.bytes_seen == '0 &&
             r_state.phase == ipos_pkg::PH_TYPE && !r_state.error_seen))
        else $error("area state not cleared after final byte");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for ip_option_security_strip_top.
// Streams IPv4 option areas through the valid/ready byte channel and checks each result
// against an in-bench option filter model; depends on ipos_pkg and the RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int AREA_MAX      = 40;    // option bytes per area before overflow
    localparam int SETTLE_CYCLES = 6;     // covers the two-stage pipe after the last result
    localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake before giving up

    // Kinds of entries in the pending stimulus queue.
    typedef enum logic [1:0] {
        ST_BYTE,   // one option byte on the input channel
        ST_CFG,    // one drop-code register write
        ST_DRAIN,  // hold the sender until every expected result has arrived
        ST_MODE    // change the idle and stall rates
    } t_stim_kind;

    typedef struct {
        t_stim_kind           kind;
        logic [7:0]           data;
        logic                 last_flag;
        ipos_pkg::t_cfg_index reg_index;
        int                   idle_pct;
        int                   stall_pct;
    } t_stim;

    // One expected result of the option filter.
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             is_last;
        ipos_pkg::t_count kept_count;
        logic             malformed;
    } t_filtered;

    // Clock, reset and DUT ports.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] opt_byte = 8'h00;
    logic       end_area = 1'b0;
    logic       o_out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_is_last;
    logic [5:0] o_kept_count;
    logic       o_malformed;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] cfg_index = ipos_pkg::CFG_SECURITY;
    logic [7:0] cfg_data = 8'h00;

    // Stimulus and expectation stores.
    t_stim      stim_q[$];
    t_filtered  filtered_q[$];
    logic [7:0] area_bytes[$];
    logic [7:0] plan_code[3];    // drop codes in force while the stimulus is built
    int         byte_total = 0;

    // Driver and monitor bookkeeping.
    logic in_took = 1'b0;
    logic cfg_took = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   settle_cnt = 0;
    bit   stim_done = 1'b0;
    bit   timed_out = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches = 0;

    // Filter model state and its copy of the drop codes.
    ipos_pkg::t_phase pr_phase;
    ipos_pkg::t_count pr_left;
    logic             pr_dropping;
    ipos_pkg::t_count pr_kept;
    ipos_pkg::t_count pr_seen;
    logic             pr_bad;
    logic [7:0]       drop_code[3];

    ip_option_security_strip_top #(
        .MAX_OPT_BYTES(AREA_MAX)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_opt_byte   (opt_byte),
        .i_end_of_area(end_area),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_is_last    (o_is_last),
        .o_kept_count (o_kept_count),
        .o_malformed  (o_malformed),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hold reset at the start, release it on a falling edge.
    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Start a new area: every per-area field returns to its idle value.
    task automatic clear_area();
        pr_phase    = ipos_pkg::PH_TYPE;
        pr_left     = '0;
        pr_dropping = 1'b0;
        pr_kept     = '0;
        pr_seen     = '0;
        pr_bad      = 1'b0;
    endtask

    // Advance the filter model by one accepted byte and queue the result it causes.
    task automatic filter_byte(input logic [7:0] b, input logic last_flag);
        int        body;
        logic      keep;
        t_filtered res;
        keep = 1'b0;
        if (int'(pr_seen) >= AREA_MAX) begin
            // Overflowing byte: flag it, neither parse nor keep it.
            pr_bad = 1'b1;
        end else begin
            pr_seen++;
            case (pr_phase)
                ipos_pkg::PH_TYPE: begin
                    if (b == ipos_pkg::OPT_END) begin
                        pr_phase = ipos_pkg::PH_STOP;
                    end else if (b != ipos_pkg::OPT_NOP) begin
                        pr_dropping = (b == drop_code[ipos_pkg::CFG_SECURITY]) ||
                                      (b == drop_code[ipos_pkg::CFG_EXTENDED]) ||
                                      (b == drop_code[ipos_pkg::CFG_COMMERCIAL]);
                        keep = !pr_dropping;
                        pr_phase = ipos_pkg::PH_LEN;
                    end
                end
                ipos_pkg::PH_LEN: begin
                    if (b < ipos_pkg::OPT_MIN_LEN) begin
                        // Bad length: drop the length byte and stop parsing.
                        pr_bad = 1'b1;
                        pr_phase = ipos_pkg::PH_STOP;
                    end else begin
                        keep = !pr_dropping;
                        if (b == ipos_pkg::OPT_MIN_LEN) begin
                            pr_phase = ipos_pkg::PH_TYPE;
                        end else begin
                            body = int'(b) - int'(ipos_pkg::OPT_MIN_LEN);
                            pr_left = (body > int'(ipos_pkg::BODY_CAP)) ?
                                      ipos_pkg::t_count'(ipos_pkg::BODY_CAP) :
                                      ipos_pkg::t_count'(body);
                            pr_phase = ipos_pkg::PH_BODY;
                        end
                    end
                end
                ipos_pkg::PH_BODY: begin
                    keep = !pr_dropping;
                    if (pr_left != 0) pr_left--;
                    if (pr_left == 0) pr_phase = ipos_pkg::PH_TYPE;
                end
                default: ;
            endcase
        end
        if (keep) pr_kept++;
        // Area ending inside an option is truncated.
        if (last_flag && (pr_phase == ipos_pkg::PH_LEN || pr_phase == ipos_pkg::PH_BODY))
            pr_bad = 1'b1;
        if (keep || last_flag) begin
            res.out_byte   = keep ? b : 8'h00;
            res.byte_valid = keep;
            res.is_last    = last_flag;
            res.kept_count = pr_kept;
            res.malformed  = pr_bad;
            filtered_q.push_back(res);
        end
        if (last_flag) clear_area();
    endtask

    task automatic queue_entry(input t_stim_kind kind, input logic [7:0] data,
                               input logic last_flag,
                               input ipos_pkg::t_cfg_index reg_index,
                               input int idle_pct, input int stall_pct);
        t_stim s;
        s.kind      = kind;
        s.data      = data;
        s.last_flag = last_flag;
        s.reg_index = reg_index;
        s.idle_pct  = idle_pct;
        s.stall_pct = stall_pct;
        stim_q.push_back(s);
    endtask

    // Move the bytes of area_bytes to the stimulus queue, marking the last one.
    task automatic flush_area();
        foreach (area_bytes[i]) begin
            queue_entry(ST_BYTE, area_bytes[i], i == area_bytes.size() - 1,
                        ipos_pkg::CFG_SECURITY, 0, 0);
        end
        byte_total += area_bytes.size();
        area_bytes = {};
    endtask

    // Build one area from well-formed options with random content; break some of them.
    task automatic add_random_area();
        int         shape;
        int         total;
        int         room;
        int         olen;
        int         k;
        logic [7:0] otype;
        shape = $urandom_range(99);
        if (shape < 5) total = $urandom_range(AREA_MAX + 1, AREA_MAX + 8);
        else if (shape < 20) total = $urandom_range(1, 8);
        else total = $urandom_range(4, AREA_MAX);
        area_bytes = {};
        while (area_bytes.size() < total) begin
            room = total - area_bytes.size();
            k = $urandom_range(99);
            if (k < 10 || room < 2) begin
                area_bytes.push_back(ipos_pkg::OPT_NOP);
            end else if (k < 14) begin
                // End of list, then trailing garbage that must be discarded.
                area_bytes.push_back(ipos_pkg::OPT_END);
                while (area_bytes.size() < total) area_bytes.push_back(8'($urandom));
            end else begin
                otype = (k < 40) ? plan_code[$urandom_range(2)] : 8'($urandom_range(2, 255));
                olen = (k < 90) ? $urandom_range(2, (room < 10) ? room : 10)
                                : $urandom_range(2, room);
                area_bytes.push_back(otype);
                area_bytes.push_back(8'(olen));
                repeat (olen - 2) area_bytes.push_back(8'($urandom));
            end
        end
        // Corrupt a quarter of the areas: tiny or random byte, or cut it short.
        if ($urandom_range(3) == 0) begin
            k = $urandom_range(area_bytes.size() - 1);
            case ($urandom_range(2))
                0: area_bytes[k] = 8'($urandom_range(1));
                1: area_bytes[k] = 8'($urandom);
                default: while (area_bytes.size() > k + 1) void'(area_bytes.pop_back());
            endcase
        end
        flush_area();
    endtask

    // Fill the stimulus queue: directed areas first, then random phases.
    initial begin : fill_stimulus
        int         p;
        int         target;
        logic [7:0] c_sec;
        logic [7:0] c_ext;
        logic [7:0] c_com;
        plan_code[ipos_pkg::CFG_SECURITY]   = ipos_pkg::RST_CODE_SECURITY;
        plan_code[ipos_pkg::CFG_EXTENDED]   = ipos_pkg::RST_CODE_EXTENDED;
        plan_code[ipos_pkg::CFG_COMMERCIAL] = ipos_pkg::RST_CODE_COMMERCIAL;
        queue_entry(ST_MODE, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 0, 0);

        // No-op, kept option, dropped security option, end of list, garbage after it.
        area_bytes = {8'h01, 8'h07, 8'h03, 8'hFF, ipos_pkg::RST_CODE_SECURITY, 8'h04,
                      8'hAA, 8'hBB, 8'h00, 8'hAB, 8'h55};
        flush_area();
        // Length of one: kept type byte stays, parsing stops.
        area_bytes = {8'h44, 8'h01, 8'h99};
        flush_area();
        // Dropped extended option, then commercial option cut off by the area end.
        area_bytes = {ipos_pkg::RST_CODE_EXTENDED, 8'h02, ipos_pkg::RST_CODE_COMMERCIAL,
                      8'h05, 8'h11, 8'h22};
        flush_area();
        // Area ends right after a type byte.
        area_bytes = {8'hFF};
        flush_area();
        // Lone end of list.
        area_bytes = {8'h00};
        flush_area();
        // Length of zero.
        area_bytes = {8'h07, 8'h00};
        flush_area();

        for (p = 0; p < 8; p++) begin
            queue_entry(ST_DRAIN, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 0, 0);
            c_sec = 8'($urandom);
            c_ext = 8'($urandom);
            c_com = 8'($urandom);
            case (p)
                1: begin c_sec = 8'd0;   c_ext = 8'd1;   c_com = 8'd255; end
                2: begin c_sec = 8'd255; c_ext = 8'd2;   c_com = 8'd68;  end
                4: begin
                    c_sec = ipos_pkg::RST_CODE_SECURITY;
                    c_ext = ipos_pkg::RST_CODE_EXTENDED;
                    c_com = ipos_pkg::RST_CODE_COMMERCIAL;
                end
                6: begin c_sec = 8'd7;   c_ext = 8'd7;   c_com = 8'd7;   end
                default: ;
            endcase
            // Phase 0 runs on the reset codes.
            if (p != 0) begin
                queue_entry(ST_CFG, c_sec, 1'b0, ipos_pkg::CFG_SECURITY, 0, 0);
                queue_entry(ST_CFG, c_ext, 1'b0, ipos_pkg::CFG_EXTENDED, 0, 0);
                queue_entry(ST_CFG, c_com, 1'b0, ipos_pkg::CFG_COMMERCIAL, 0, 0);
                plan_code[ipos_pkg::CFG_SECURITY]   = c_sec;
                plan_code[ipos_pkg::CFG_EXTENDED]   = c_ext;
                plan_code[ipos_pkg::CFG_COMMERCIAL] = c_com;
            end
            case (p % 4)
                0: queue_entry(ST_MODE, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 0, 0);
                1: queue_entry(ST_MODE, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 79, 0);
                2: queue_entry(ST_MODE, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 0, 79);
                default: queue_entry(ST_MODE, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 38, 38);
            endcase
            target = byte_total + 160;
            while (byte_total < target) begin
                // Now and then hold the sender until the pipe has drained.
                if ($urandom_range(19) == 0) begin
                    queue_entry(ST_DRAIN, 8'h00, 1'b0, ipos_pkg::CFG_SECURITY, 0, 0);
                end
                add_random_area();
            end
        end
    end

    // Driver: change inputs on the falling edge, one nonblocking write per signal.
    always @(negedge clk) begin : drive_items
        t_stim s;
        logic  next_in;
        logic  next_cfg;
        // Hold an item that has not been taken yet.
        next_in  = in_valid && !in_took;
        next_cfg = cfg_valid && !cfg_took;
        if (rst_n && !next_in && !next_cfg) begin
            if (settle_cnt > 0) begin
                settle_cnt--;
            end else if (stim_q.size() == 0) begin
                stim_done = 1'b1;
            end else begin
                s = stim_q[0];
                case (s.kind)
                    ST_MODE: begin
                        send_idle_pct  = s.idle_pct;
                        recv_stall_pct = s.stall_pct;
                        void'(stim_q.pop_front());
                    end
                    ST_DRAIN: begin
                        // Wait for the last result, then let dropped bytes clear the pipe.
                        if (filtered_q.size() == 0) begin
                            settle_cnt = SETTLE_CYCLES;
                            void'(stim_q.pop_front());
                        end
                    end
                    ST_CFG: begin
                        next_cfg = 1'b1;
                        cfg_index <= s.reg_index;
                        cfg_data  <= s.data;
                        void'(stim_q.pop_front());
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            next_in = 1'b1;
                            opt_byte <= s.data;
                            end_area <= s.last_flag;
                            void'(stim_q.pop_front());
                        end
                    end
                endcase
            end
        end
        in_valid  <= next_in;
        cfg_valid <= next_cfg;
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sample both channels on the rising edge, predict and check.
    always @(posedge clk) begin : watch_results
        t_filtered e;
        if (!rst_n) begin
            in_took  <= 1'b0;
            cfg_took <= 1'b0;
            drop_code[ipos_pkg::CFG_SECURITY]   = ipos_pkg::RST_CODE_SECURITY;
            drop_code[ipos_pkg::CFG_EXTENDED]   = ipos_pkg::RST_CODE_EXTENDED;
            drop_code[ipos_pkg::CFG_COMMERCIAL] = ipos_pkg::RST_CODE_COMMERCIAL;
            clear_area();
        end else begin
            in_took  <= in_valid && o_in_ready;
            cfg_took <= cfg_valid && o_cfg_ready;

            if (o_out_valid && out_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result: byte %02h valid %0b last %0b count %0d",
                             $time, o_out_byte, o_byte_valid, o_is_last, o_kept_count);
                    mismatches++;
                end else begin
                    e = filtered_q.pop_front();
                    if (o_out_byte !== e.out_byte) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, e.out_byte, o_out_byte);
                        mismatches++;
                    end
                    if (o_byte_valid !== e.byte_valid) begin
                        $display("%0t: byte_valid expected %0b actual %0b",
                                 $time, e.byte_valid, o_byte_valid);
                        mismatches++;
                    end
                    if (o_is_last !== e.is_last) begin
                        $display("%0t: is_last expected %0b actual %0b",
                                 $time, e.is_last, o_is_last);
                        mismatches++;
                    end
                    if (o_kept_count !== e.kept_count) begin
                        $display("%0t: kept_count expected %0d actual %0d",
                                 $time, e.kept_count, o_kept_count);
                        mismatches++;
                    end
                    if (o_malformed !== e.malformed) begin
                        $display("%0t: malformed expected %0b actual %0b",
                                 $time, e.malformed, o_malformed);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && o_cfg_ready) drop_code[cfg_index] = cfg_data;
            if (in_valid && o_in_ready) filter_byte(opt_byte, end_area);

            // Watchdog: count cycles in which no channel moves anything.
            if ((in_valid && o_in_ready) || (cfg_valid && o_cfg_ready) ||
                (o_out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else if (!timed_out) begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                             $time, QUIET_LIMIT, filtered_q.size());
                    timed_out = 1'b1;
                end
            end
        end
    end

    // End of run: wait for the last expectation, let the pipe settle, then report.
    initial begin : finish_run
        wait (rst_n);
        while (!timed_out && !(stim_done && filtered_q.size() == 0)) @(negedge clk);
        if (!timed_out) repeat (SETTLE_CYCLES) @(posedge clk);
        if (!timed_out && mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
